### hdl/leb_pkg.sv
// Shared constants, command codes and controller/datapath interface types.
package leb_pkg;

    localparam int BUFFER_SIZE = 64;
    localparam int IDX_W       = (BUFFER_SIZE > 2) ? $clog2(BUFFER_SIZE) : 1;
    localparam int CHAR_W      = 7;
    localparam int CMD_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHAR      = 3'd0,
        CMD_DELETE    = 3'd1,
        CMD_BACKSPACE = 3'd2,
        CMD_ENTER     = 3'd3,
        CMD_LEFT      = 3'd4,
        CMD_RIGHT     = 3'd5,
        CMD_HOME      = 3'd6,
        CMD_END       = 3'd7
    } t_cmd;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_SETUP_INS,
        DP_RD_PREV,
        DP_WR_DN,
        DP_INS_FINAL,
        DP_SETUP_DEL,
        DP_RD_NEXT,
        DP_WR_UP,
        DP_DEL_FINAL,
        DP_CUR_DEC,
        DP_CUR_INC,
        DP_CUR_HOME,
        DP_CUR_END,
        DP_SETUP_EMIT,
        DP_RD_CUR,
        DP_EMIT,
        DP_EMIT_EMPTY
    } t_dp_op;

    typedef struct packed {
        t_cmd cmd;
        logic key_ok;
        logic cur_gt0;
        logic cur_lt_len;
        logic len_zero;
        logic ins_more;
        logic del_more;
        logic emit_last;
    } t_dp_stat;

endpackage

### hdl/leb_ctrl.sv
// Controller state machine sequencing each key request through the datapath.
module leb_ctrl
    import leb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECODE    = 9'b000000010,
        S_INS_CHK   = 9'b000000100,
        S_INS_WR    = 9'b000001000,
        S_DEL_START = 9'b000010000,
        S_DEL_CHK   = 9'b000100000,
        S_DEL_WR    = 9'b001000000,
        S_EMIT_RD   = 9'b010000000,
        S_EMIT_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = DP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_stat.cmd)
                    CMD_CHAR: begin
                        if (i_stat.key_ok) begin
                            o_op    = DP_SETUP_INS;
                            n_state = S_INS_CHK;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.cur_lt_len) begin
                            n_state = S_DEL_START;
                        end
                    end
                    CMD_BACKSPACE: begin
                        if (i_stat.cur_gt0) begin
                            o_op    = DP_CUR_DEC;
                            n_state = S_DEL_START;
                        end
                    end
                    CMD_ENTER: begin
                        if (i_stat.len_zero) begin
                            o_op = DP_EMIT_EMPTY;
                        end else begin
                            o_op    = DP_SETUP_EMIT;
                            n_state = S_EMIT_RD;
                        end
                    end
                    CMD_LEFT: begin
                        if (i_stat.cur_gt0) begin
                            o_op = DP_CUR_DEC;
                        end
                    end
                    CMD_RIGHT: begin
                        if (i_stat.cur_lt_len) begin
                            o_op = DP_CUR_INC;
                        end
                    end
                    CMD_HOME: o_op = DP_CUR_HOME;
                    CMD_END:  o_op = DP_CUR_END;
                    default:  o_op = DP_NOP;
                endcase
            end
            S_INS_CHK: begin
                if (i_stat.ins_more) begin
                    o_op    = DP_RD_PREV;
                    n_state = S_INS_WR;
                end else begin
                    o_op    = DP_INS_FINAL;
                    n_state = S_IDLE;
                end
            end
            S_INS_WR: begin
                o_op    = DP_WR_DN;
                n_state = S_INS_CHK;
            end
            S_DEL_START: begin
                o_op    = DP_SETUP_DEL;
                n_state = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (i_stat.del_more) begin
                    o_op    = DP_RD_NEXT;
                    n_state = S_DEL_WR;
                end else begin
                    o_op    = DP_DEL_FINAL;
                    n_state = S_IDLE;
                end
            end
            S_DEL_WR: begin
                o_op    = DP_WR_UP;
                n_state = S_DEL_CHK;
            end
            S_EMIT_RD: begin
                o_op    = DP_RD_CUR;
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                o_op    = DP_EMIT;
                n_state = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

### hdl/leb_datapath.sv
// Datapath: line store, length, cursor, walk index and result registers.
module leb_datapath
    import leb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_op            i_op,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CHAR_W-1:0] i_key_char,
    output t_dp_stat          o_stat,
    output logic              o_strobe,
    output logic [CHAR_W-1:0] o_line_char,
    output logic              o_is_last,
    output logic              o_empty_line
);

    logic [CHAR_W-1:0] r_mem [BUFFER_SIZE];

    t_cmd              r_cmd, n_cmd;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [IDX_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CHAR_W-1:0] r_rdata;
    logic              r_strobe, n_strobe;
    logic [CHAR_W-1:0] r_line_char, n_line_char;
    logic              r_is_last, n_is_last;
    logic              r_empty, n_empty;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic [IDX_W:0]    idx_p1;

    assign idx_p1 = {1'b0, r_idx} + {{IDX_W{1'b0}}, 1'b1};

    assign o_stat.cmd        = r_cmd;
    assign o_stat.key_ok     = (r_char != '0) && (r_len < IDX_W'(BUFFER_SIZE - 1));
    assign o_stat.cur_gt0    = (r_cur != '0);
    assign o_stat.cur_lt_len = (r_cur < r_len);
    assign o_stat.len_zero   = (r_len == '0);
    assign o_stat.ins_more   = (r_idx > r_cur);
    assign o_stat.del_more   = (idx_p1 < {1'b0, r_len});
    assign o_stat.emit_last  = (idx_p1 == {1'b0, r_len});

    always_comb begin
        n_cmd       = r_cmd;
        n_char      = r_char;
        n_len       = r_len;
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_strobe    = 1'b0;
        n_line_char = r_line_char;
        n_is_last   = r_is_last;
        n_empty     = r_empty;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_rdata;
        unique case (i_op)
            DP_NOP: ;
            DP_LATCH: begin
                n_cmd  = t_cmd'(i_cmd);
                n_char = i_key_char;
            end
            DP_SETUP_INS: n_idx = r_len;
            DP_RD_PREV: begin
                rd_en   = 1'b1;
                rd_addr = r_idx - IDX_W'(1);
            end
            DP_WR_DN: begin
                wr_en = 1'b1;
                n_idx = r_idx - IDX_W'(1);
            end
            DP_INS_FINAL: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = r_char;
                n_len   = r_len + IDX_W'(1);
                n_cur   = r_cur + IDX_W'(1);
            end
            DP_SETUP_DEL: n_idx = r_cur;
            DP_RD_NEXT: begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[IDX_W-1:0];
            end
            DP_WR_UP: begin
                wr_en = 1'b1;
                n_idx = idx_p1[IDX_W-1:0];
            end
            DP_DEL_FINAL:  n_len = r_len - IDX_W'(1);
            DP_CUR_DEC:    n_cur = r_cur - IDX_W'(1);
            DP_CUR_INC:    n_cur = r_cur + IDX_W'(1);
            DP_CUR_HOME:   n_cur = '0;
            DP_CUR_END:    n_cur = r_len;
            DP_SETUP_EMIT: n_idx = '0;
            DP_RD_CUR:     rd_en = 1'b1;
            DP_EMIT: begin
                n_strobe    = 1'b1;
                n_line_char = r_rdata;
                n_is_last   = o_stat.emit_last;
                n_empty     = 1'b0;
                n_idx       = idx_p1[IDX_W-1:0];
                if (o_stat.emit_last) begin
                    n_len = '0;
                    n_cur = '0;
                end
            end
            DP_EMIT_EMPTY: begin
                n_strobe    = 1'b1;
                n_line_char = '0;
                n_is_last   = 1'b1;
                n_empty     = 1'b1;
                n_len       = '0;
                n_cur       = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_cur    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_cur    <= n_cur;
            r_strobe <= n_strobe;
        end
        r_cmd       <= n_cmd;
        r_char      <= n_char;
        r_idx       <= n_idx;
        r_line_char <= n_line_char;
        r_is_last   <= n_is_last;
        r_empty     <= n_empty;
    end

    assign o_strobe     = r_strobe;
    assign o_line_char  = r_line_char;
    assign o_is_last    = r_is_last;
    assign o_empty_line = r_empty;

endmodule

### hdl/line_edit_buffer_unit.sv
// Line edit buffer: cursor-based command line editor emitting the line on enter.
// Insert shifts the stored characters from the cursor onwards up by one entry, delete
// and backspace shift them down by one, and enter emits every stored character in order.
// A new request is taken only while busy is low; start is ignored while busy is high.
// Results leave with o_strobe high for one cycle; no stall.
// Synchronous active-low reset clears length, cursor and control; store undefined.
module line_edit_buffer_unit
    import leb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CHAR_W-1:0] i_key_char,
    output logic              o_strobe,
    output logic [CHAR_W-1:0] o_line_char,
    output logic              o_is_last,
    output logic              o_empty_line
);

    t_dp_op   op;
    t_dp_stat stat;

    leb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_op    (op)
    );

    leb_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_cmd        (i_cmd),
        .i_key_char   (i_key_char),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_line_char  (o_line_char),
        .o_is_last    (o_is_last),
        .o_empty_line (o_empty_line)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy == !o_is_last))
        else $error("line emission and busy disagree");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_empty_line) |-> (o_is_last && (o_line_char == '0)))
        else $error("malformed empty-line result");
`endif

endmodule
